@@ hw/rtl/npdd_pkg.sv @@
// shared types, codes and the nibble lookup for the packed digit decoder
`default_nettype none
package npdd_pkg;

  typedef enum logic [1:0] {
    PH_AWAIT_MARKER = 2'd0,
    PH_NORMAL       = 2'd1,
    PH_AWAIT_COUNT  = 2'd2,
    PH_PACKED       = 2'd3
  } phase_t;

  localparam int unsigned CharW = 8;
  localparam int unsigned LeftW = 7;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             bad_nibble;
    logic             last;
  } res_t;

  // decoder state held by the top level
  typedef struct packed {
    phase_t           phase;
    logic [CharW-1:0] marker;
    logic [LeftW-1:0] packed_left;
  } dec_state_t;

  // what one input byte produces
  typedef struct packed {
    dec_state_t state;
    logic [1:0] res_count;
    res_t       res0;
    res_t       res1;
  } dec_out_t;

  localparam logic [CharW-1:0] AsciiZero   = 8'd48;
  localparam logic [CharW-1:0] AsciiDollar = 8'h24;
  localparam logic [CharW-1:0] AsciiComma  = 8'h2c;
  localparam logic [CharW-1:0] AsciiPeriod = 8'h2e;
  localparam logic [CharW-1:0] AsciiStar   = 8'h2a;

  function automatic res_t nibble_to_res(input logic [3:0] nib, input logic last);
    res_t r;
    r.last       = last;
    r.bad_nibble = 1'b0;
    unique case (nib)
      4'd10:   r.out_char = AsciiDollar;
      4'd11:   r.out_char = AsciiComma;
      4'd12:   r.out_char = AsciiPeriod;
      4'd13:   r.out_char = AsciiStar;
      4'd14, 4'd15: begin
        r.out_char   = '0;
        r.bad_nibble = 1'b1;
      end
      default: r.out_char = AsciiZero + {4'd0, nib};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/npdd_decode.sv @@
// next-state and result logic for one compressed byte
`default_nettype none
module npdd_decode (
  input  wire logic [7:0]           in_byte,
  input  wire logic                 start_req,
  input  wire npdd_pkg::dec_state_t cur,
  output npdd_pkg::dec_out_t        dec
);
  import npdd_pkg::*;

  logic [LeftW-1:0] left_dec;

  assign left_dec = cur.packed_left - LeftW'(1);

  always_comb begin
    dec.state     = cur;
    dec.res_count = 2'd0;
    dec.res0      = '{out_char: in_byte, bad_nibble: 1'b0, last: 1'b1};
    dec.res1      = '{out_char: '0, bad_nibble: 1'b0, last: 1'b1};
    if (start_req || cur.phase == PH_AWAIT_MARKER) begin
      dec.state.marker      = in_byte;
      dec.state.phase       = PH_NORMAL;
      dec.state.packed_left = '0;
    end else begin
      unique case (cur.phase)
        PH_NORMAL: begin
          if (in_byte == cur.marker) begin
            dec.state.phase = PH_AWAIT_COUNT;
          end else begin
            dec.res_count = 2'd1;
          end
        end
        PH_AWAIT_COUNT: begin
          dec.state.packed_left = in_byte[7:1];
          dec.state.phase = (in_byte[7:1] != '0) ? PH_PACKED : PH_NORMAL;
        end
        default: begin
          dec.res_count         = 2'd2;
          dec.res0              = nibble_to_res(in_byte[7:4], 1'b0);
          dec.res1              = nibble_to_res(in_byte[3:0], 1'b1);
          dec.state.packed_left = left_dec;
          if (left_dec == '0) begin
            dec.state.phase = PH_NORMAL;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/nibble_packed_digit_decoder.sv @@
// top level: half-byte packed digit stream decompressor
// timing: a result appears in the cycle after the transaction that causes it
// throughput, while m_tready holds: one input byte per cycle for plain bytes;
//   the single output port drains the two-entry result buffer one character
//   per cycle, so the byte after a packed one waits until a character leaves
// reset: synchronous, active high; phase returns to await marker, marker and
//   packed count clear, the result buffer empties
`default_nettype none
module nibble_packed_digit_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic       s_tuser,   // [0] start_req
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_char
  output logic            m_tuser,   // [0] bad_nibble
  output logic            m_tlast    // final result of its input byte
);
  import npdd_pkg::*;

  dec_state_t state;
  dec_out_t   dec;

  // result buffer: slot0 drives the port, slot1 shifts down on a pop
  res_t       slot0;
  res_t       slot1;
  logic [1:0] count;

  logic s_fire;
  logic m_fire;

  npdd_decode u_decode (
    .in_byte   (s_tdata),
    .start_req (s_tuser),
    .cur       (state),
    .dec       (dec)
  );

  assign m_fire   = m_tvalid && m_tready;
  // take a new byte once the buffer is empty or its last entry leaves now
  assign s_tready = (count == 2'd0) || (count == 2'd1 && m_tready);
  assign s_fire   = s_tvalid && s_tready;

  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = slot0.out_char;
  assign m_tuser  = slot0.bad_nibble;
  assign m_tlast  = slot0.last;

  // decoder state and buffer occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= PH_AWAIT_MARKER;
      state.marker      <= '0;
      state.packed_left <= '0;
      count             <= 2'd0;
    end else begin
      if (s_fire) begin
        state <= dec.state;
        count <= dec.res_count;
      end else if (m_fire) begin
        count <= count - 2'd1;
      end
    end
  end

  // buffer payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_fire) begin
      slot0 <= dec.res0;
      slot1 <= dec.res1;
    end else if (m_fire) begin
      slot0 <= slot1;
    end
  end

endmodule
`default_nettype wire

@@ sim/nibble_packed_digit_decoder_tb.sv @@
// self-checking testbench for the packed digit decoder: predictor, scoreboard and stream drivers
`default_nettype none

import npdd_pkg::*;

// tracks the decoder state and keeps the characters still owed by the block
class decode_tracker;
  phase_t      ph;
  logic [7:0]  esc;
  logic [6:0]  left;
  res_t        pending_chars[$];
  int unsigned faults;

  function new();
    ph     = PH_AWAIT_MARKER;
    esc    = '0;
    left   = '0;
    faults = 0;
  endfunction

  // one packed nibble as a character
  function res_t nibble_char(input logic [3:0] nib, input logic fin);
    res_t r;
    r.last       = fin;
    r.bad_nibble = 1'b0;
    if (nib < 4'd10) begin
      r.out_char = 8'd48 + {4'd0, nib};
    end else begin
      case (nib)
        4'd10:   r.out_char = "$";
        4'd11:   r.out_char = ",";
        4'd12:   r.out_char = ".";
        4'd13:   r.out_char = "*";
        default: begin
          r.out_char   = 8'd0;
          r.bad_nibble = 1'b1;
        end
      endcase
    end
    return r;
  endfunction

  // accepted input transaction: advance the state, queue what it yields
  function void take_byte(input logic [7:0] b, input logic st);
    res_t r;
    if (st || ph == PH_AWAIT_MARKER) begin
      esc  = b;
      ph   = PH_NORMAL;
      left = '0;
      return;
    end
    case (ph)
      PH_NORMAL: begin
        if (b == esc) begin
          ph = PH_AWAIT_COUNT;
        end else begin
          r.out_char   = b;
          r.bad_nibble = 1'b0;
          r.last       = 1'b1;
          pending_chars.push_back(r);
        end
      end
      PH_AWAIT_COUNT: begin
        left = b[7:1];
        ph   = (left != 7'd0) ? PH_PACKED : PH_NORMAL;
      end
      default: begin
        pending_chars.push_back(nibble_char(b[7:4], 1'b0));
        pending_chars.push_back(nibble_char(b[3:0], 1'b1));
        left = left - 7'd1;
        if (left == 7'd0) ph = PH_NORMAL;
      end
    endcase
  endfunction

  // accepted output transaction against the oldest owed character
  function void match_char(input res_t got);
    res_t want;
    if (pending_chars.size() == 0) begin
      faults++;
      if (faults <= 10)
        $display("unexpected output: char=%h bad=%b last=%b",
                 got.out_char, got.bad_nibble, got.last);
      return;
    end
    want = pending_chars.pop_front();
    if (got.out_char !== want.out_char || got.bad_nibble !== want.bad_nibble ||
        got.last !== want.last) begin
      faults++;
      if (faults <= 10)
        $display("mismatch: expected char=%h bad=%b last=%b, got char=%h bad=%b last=%b",
                 want.out_char, want.bad_nibble, want.last,
                 got.out_char, got.bad_nibble, got.last);
    end
  endfunction
endclass

module nibble_packed_digit_decoder_tb;

  localparam int unsigned RandItems = 1350;
  localparam int unsigned QuietTail = 150;
  localparam int unsigned HoldCycles = 300;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tuser;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       m_tlast;

  decode_tracker tracker;
  res_t          seen_char;
  int unsigned   sent;
  bit            quiet;
  bit            long_hold_req;

  nibble_packed_digit_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // output side: sample each accepted transaction at the edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_char.out_char   = m_tdata;
      seen_char.bad_nibble = m_tuser;
      seen_char.last       = m_tlast;
      tracker.match_char(seen_char);
    end
  end

  // output side: ready with random stall bursts, plus one long hold-off on request
  initial begin : rx_side
    int unsigned n;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        m_tready <= 1'b0;
        for (n = 0; n < HoldCycles; n++) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        // ready also stays low across the loop edge
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 17)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // one input transaction, optionally preceded by an idle burst
  task automatic offer(input logic [7:0] b, input logic st);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tuser  <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= st;
    do @(posedge clk); while (!s_tready);
    tracker.take_byte(b, st);
    sent++;
  endtask

  // stop offering until every owed character has come out
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_chars.size() != 0) @(posedge clk);
  endtask

  // escape, count, then the packed bytes; sometimes cut short by a new file
  task automatic escape_run();
    int unsigned k;
    int unsigned i;
    logic [7:0]  b;
    if ($urandom_range(0, 24) == 0)
      k = $urandom_range(0, 1) ? 255 : $urandom_range(13, 255);
    else
      k = $urandom_range(0, 12);
    offer(tracker.esc, 1'b0);
    offer(8'(k), 1'b0);
    for (i = 0; i < k / 2; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        offer(8'($urandom), 1'b1);
        break;
      end
      b = ($urandom_range(0, 9) == 0) ? tracker.esc : 8'($urandom);
      offer(b, 1'b0);
    end
  endtask

  initial begin : stimulus
    int unsigned pick;
    logic [7:0]  b;
    bit          hold_done;
    bit          drain_done;

    tracker       = new();
    sent          = 0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    hold_done     = 1'b0;
    drain_done    = 1'b0;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = 8'd0;
    s_tuser       = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // first byte after reset without a start request still becomes the marker
    offer(8'hA5, 1'b0);
    offer(8'h00, 1'b0);
    offer(8'hFF, 1'b0);
    // counts of zero and one carry no packed bytes
    offer(8'hA5, 1'b0);
    offer(8'h00, 1'b0);
    offer(8'hA5, 1'b0);
    offer(8'h01, 1'b0);
    // odd count 19 gives nine packed bytes: every nibble, then the marker as data
    offer(8'hA5, 1'b0);
    offer(8'h13, 1'b0);
    offer(8'h01, 1'b0);
    offer(8'h23, 1'b0);
    offer(8'h45, 1'b0);
    offer(8'h67, 1'b0);
    offer(8'h89, 1'b0);
    offer(8'hAB, 1'b0);
    offer(8'hCD, 1'b0);
    offer(8'hEF, 1'b0);
    offer(8'hA5, 1'b0);
    // new file, then a start request in the middle of packed data
    offer(8'h00, 1'b1);
    offer(8'h00, 1'b0);
    offer(8'h04, 1'b0);
    offer(8'h12, 1'b0);
    offer(8'hFF, 1'b1);
    offer(8'h00, 1'b0);

    sent = 0;
    while (sent < RandItems) begin
      if (!hold_done && sent >= 400) begin
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
      end
      if (!drain_done && sent >= 800) begin
        wait_for_drain();
        drain_done = 1'b1;
      end
      if (sent >= RandItems - QuietTail) quiet = 1'b1;

      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // new file with a random marker, extremes now and then
        case ($urandom_range(0, 3))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom);
        endcase
        offer(b, 1'b1);
      end else if (pick < 12) begin
        // noise, start bit included
        offer(8'($urandom), 1'($urandom_range(0, 19) == 0));
      end else if (pick < 55) begin
        b = 8'($urandom);
        if (tracker.ph == PH_NORMAL && b == tracker.esc) b = b ^ 8'h01;
        offer(b, 1'b0);
      end else begin
        escape_run();
      end
    end

    quiet = 1'b1;
    wait_for_drain();
    repeat (20) @(posedge clk);
    if (tracker.faults == 0 && tracker.pending_chars.size() == 0) begin
      $display("nibble_packed_digit_decoder test passed");
    end else begin
      $display("nibble_packed_digit_decoder test failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("nibble_packed_digit_decoder test failed");
    $finish;
  end

endmodule

`default_nettype wire
